// ===== rtl/sgt_pkg.sv =====
// shared types and constants for the sobel gradient threshold block
`default_nettype none
package sgt_pkg;

  localparam int PIXEL_W = 8;
  localparam int GRAD_W = 11;
  localparam int COORD_W = 11;
  localparam int WIDTH_REG_W = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int OUT_DATA_W = 40;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [GRAD_W-1:0] THRESH_RESET = 11'd0;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // item kind on the input side
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] t;
    logic [PIXEL_W-1:0] m;
    logic [PIXEL_W-1:0] b;
  } col3_t;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0] image_width;
    logic [GRAD_W-1:0] gradient_threshold;
  } cfg_t;

  typedef struct packed {
    logic [GRAD_W-1:0] gradient;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic last_in_run;
    logic frame_done;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/sgt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module sgt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sgt_regs.sv =====
// apb configuration registers
`default_nettype none
module sgt_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sgt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [sgt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [sgt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output sgt_pkg::cfg_t                         cfg
);
  import sgt_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= WIDTH_RESET;
      cfg.gradient_threshold <= THRESH_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: cfg.image_width <= pwdata[WIDTH_REG_W-1:0];
        REG_THRESHOLD:   cfg.gradient_threshold <= pwdata[GRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = CFG_DATA_W'(cfg.image_width);
      REG_THRESHOLD:   prdata = CFG_DATA_W'(cfg.gradient_threshold);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sgt_kernel.sv =====
// 3x3 sobel l1 magnitude with threshold
`default_nettype none
module sgt_kernel (
  input  wire sgt_pkg::col3_t                left,
  input  wire sgt_pkg::col3_t                center,
  input  wire sgt_pkg::col3_t                right,
  input  wire logic [sgt_pkg::GRAD_W-1:0]    threshold,
  output logic      [sgt_pkg::GRAD_W-1:0]    gradient
);
  import sgt_pkg::*;

  localparam int SW = PIXEL_W + 2;

  logic [SW-1:0] lsum, rsum, tsum, bsum;
  logic [SW-1:0] ax, ay;
  logic [GRAD_W-1:0] mag;

  always_comb begin
    lsum = SW'(left.t) + {1'b0, left.m, 1'b0} + SW'(left.b);
    rsum = SW'(right.t) + {1'b0, right.m, 1'b0} + SW'(right.b);
    tsum = SW'(left.t) + {1'b0, center.t, 1'b0} + SW'(right.t);
    bsum = SW'(left.b) + {1'b0, center.b, 1'b0} + SW'(right.b);
    ax = (lsum >= rsum) ? lsum - rsum : rsum - lsum;
    ay = (tsum >= bsum) ? tsum - bsum : bsum - tsum;
    mag = GRAD_W'(ax) + GRAD_W'(ay);
    gradient = (mag > threshold) ? mag : '0;
  end

endmodule
`default_nettype wire

// ===== rtl/sobel_gradient_threshold.sv =====
// top level of the streaming sobel gradient threshold block
//
// pixels enter on the s_ stream in raster order, s_tuser low for a pixel item
// and high for an end-of-frame pad item (one pad per column closes the frame).
// results leave on the m_ stream one row behind the input: the item at column
// c of row r releases the result of column c-1 of row r-1, and the last column
// item of a row also releases that row's last result, so one item gives zero,
// one or two results. m_tlast marks the last result of an item, m_tuser the
// final result of the frame.
// an item's results pass through the working register, loaded together with the
// line buffer read when the item is accepted, and then the output register.
// throughput: one item per cycle while the output takes results, set by the
// single line buffer ram port pair; an item that releases two results holds back
// the next item that has results while its second result waits in the second slot.
// when m_tready is low, results wait in the output register and its one-entry
// second slot, and s_tready drops once the working stage cannot drain.
// reset clears the counters, the window and both registers (width 640,
// threshold 0); line buffer contents are not cleared. the user must write
// configuration over apb only while the block is idle; the block does not enforce it.
`default_nettype none
module sobel_gradient_threshold #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // apb configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sgt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [sgt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [sgt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sgt_pkg::PIXEL_W-1:0]      s_tdata,   // pixel
  input  wire logic                             s_tuser,   // kind
  // output stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [sgt_pkg::OUT_DATA_W-1:0]   m_tdata,   // gradient, column, row, zero fill
  output logic                                  m_tlast,   // last_in_run
  output logic                                  m_tuser    // frame_done
);
  import sgt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

  cfg_t cfg;

  sgt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // position counters
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [LW-1:0] w_ext, w_eff;
  logic in_last, in_accept;

  // working stage
  logic s1_valid, s1_kind, s1_last;
  logic [PIXEL_W-1:0] s1_pix;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic s1_retire;

  // window of the two previous columns
  col3_t w0, w1, cur, left0;

  // line buffers: {line_above, line_current}
  logic [2*PIXEL_W-1:0] lb_rdata, lb_wdata;
  logic lb_we;
  logic [PIXEL_W-1:0] above_pix, current_pix;

  // results
  logic [GRAD_W-1:0] grad0, grad1;
  logic res0_v, res1_v, res_any;
  res_t res0, res1, first_res, out_res, pend_res;
  logic pend_valid, out_free;

  assign w_ext = LW'(cfg.image_width);
  assign w_eff = (w_ext < LW'(3)) ? LW'(3) :
                 ((w_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : w_ext);
  assign in_last = LW'(col) >= (w_eff - LW'(1));
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    col_next = col;
    row_next = row;
    if (in_accept) begin
      if (in_last) begin
        col_next = '0;
        if (s_tuser == KIND_PAD) begin
          row_next = '0;
        end else if (row < RW'(MAX_HEIGHT)) begin
          row_next = row + RW'(1);
        end
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  sgt_ram #(
    .WIDTH (2 * PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s1_col),
    .wdata (lb_wdata),
    .re    (in_accept),
    .raddr (col),
    .rdata (lb_rdata)
  );

  assign above_pix = lb_rdata[2*PIXEL_W-1:PIXEL_W];
  assign current_pix = lb_rdata[PIXEL_W-1:0];
  assign lb_we = s1_retire && (s1_kind == KIND_PIXEL);
  assign lb_wdata = {current_pix, s1_pix};

  assign s_tready = !s1_valid || s1_retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind <= s_tuser;
      s1_pix <= s_tdata;
      s1_col <= col;
      s1_row <= row;
      s1_last <= in_last;
    end
  end

  // current column with mirrored rows at the frame edges
  always_comb begin
    cur.m = current_pix;
    if (s1_kind == KIND_PIXEL) begin
      cur.b = s1_pix;
      cur.t = (s1_row == RW'(1)) ? s1_pix : above_pix;
    end else if (s1_row >= RW'(2)) begin
      cur.t = above_pix;
      cur.b = above_pix;
    end else begin
      cur.t = current_pix;
      cur.b = current_pix;
    end
    left0 = (s1_col == CW'(1)) ? cur : w1;
  end

  sgt_kernel u_kernel0 (
    .left      (left0),
    .center    (w0),
    .right     (cur),
    .threshold (cfg.gradient_threshold),
    .gradient  (grad0)
  );

  sgt_kernel u_kernel1 (
    .left      (w0),
    .center    (cur),
    .right     (w0),
    .threshold (cfg.gradient_threshold),
    .gradient  (grad1)
  );

  always_comb begin
    res0_v = (s1_row != '0) && (s1_col != '0);
    res1_v = (s1_row != '0) && s1_last;
    res_any = res0_v || res1_v;

    res0.gradient = grad0;
    res0.column = COORD_W'(s1_col - CW'(1));
    res0.row = COORD_W'(s1_row - RW'(1));
    res0.last_in_run = !res1_v;
    res0.frame_done = 1'b0;

    res1.gradient = grad1;
    res1.column = COORD_W'(s1_col);
    res1.row = COORD_W'(s1_row - RW'(1));
    res1.last_in_run = 1'b1;
    res1.frame_done = (s1_kind == KIND_PAD);

    first_res = res0_v ? res0 : res1;
  end

  assign out_free = !m_tvalid || (m_tready && !pend_valid);
  assign s1_retire = s1_valid && (!res_any || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      w0 <= '0;
      w1 <= '0;
    end else if (s1_retire) begin
      w1 <= w0;
      w0 <= cur;
    end
  end

  // output register plus one pending slot for the second result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (s1_retire && res_any) begin
      m_tvalid <= 1'b1;
      pend_valid <= res0_v && res1_v;
    end else if (m_tvalid && m_tready) begin
      if (pend_valid) begin
        pend_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && res_any) begin
      out_res <= first_res;
      pend_res <= res1;
    end else if (m_tvalid && m_tready && pend_valid) begin
      out_res <= pend_res;
    end
  end

  assign m_tdata = {(OUT_DATA_W - GRAD_W - 2 * COORD_W)'(0), out_res.row,
                    out_res.column, out_res.gradient};
  assign m_tlast = out_res.last_in_run;
  assign m_tuser = out_res.frame_done;

  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> m_tvalid)
    else $error("second result pending without a valid output");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end result not marked last of its item");

  a_ram_no_collide: assert property (@(posedge clk) disable iff (rst)
    (lb_we && in_accept) |-> (s1_col != col))
    else $error("line buffer read and write at the same column");

  a_pad_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser && in_last) |=> (row == '0 && col == '0))
    else $error("counters not cleared after the last pad item");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_retire) |=> (s1_valid && $stable(s1_col) && $stable(s1_row)))
    else $error("working stage item lost while stalled");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the sobel gradient threshold stream block
`timescale 1ns / 1ps
module tb_top;
  import sgt_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  localparam int SETTLE = 8;
  localparam int HOLD_OFF = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 900;
  localparam int FILL_WIDTH = 40;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FLAT, PIX_NEAR} pix_style_e;

  class gradient_scoreboard;
    logic [WIDTH_REG_W-1:0] image_width;
    logic [GRAD_W-1:0] threshold;
    bit [PIXEL_W-1:0] line_above [MAX_W];
    bit [PIXEL_W-1:0] line_current [MAX_W];
    col3_t window [2];
    int column_count;
    int row_count;
    res_t pending_gradients [$];
    int mismatches;

    function new();
      image_width = WIDTH_RESET;
      threshold = THRESH_RESET;
      window[0] = '0;
      window[1] = '0;
      column_count = 0;
      row_count = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        image_width = value[WIDTH_REG_W-1:0];
      end else begin
        threshold = value[GRAD_W-1:0];
      end
    endfunction

    function int row_length();
      if (image_width < 3) return 3;
      if (image_width > MAX_W) return MAX_W;
      return int'(image_width);
    endfunction

    function bit frame_start();
      return column_count == 0 && row_count == 0;
    endfunction

    function logic [GRAD_W-1:0] sobel_magnitude(col3_t l, col3_t m, col3_t r);
      int gx;
      int gy;
      int sum;
      gx = int'(l.t) + 2 * int'(l.m) + int'(l.b) - int'(r.t) - 2 * int'(r.m) - int'(r.b);
      gy = int'(l.t) + 2 * int'(m.t) + int'(r.t) - int'(l.b) - 2 * int'(m.b) - int'(r.b);
      sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      return (sum > int'(threshold)) ? sum[GRAD_W-1:0] : '0;
    endfunction

    function void expect_gradient(logic [GRAD_W-1:0] g, int col, int row, bit last, bit done);
      res_t e;
      e.gradient = g;
      e.column = col[COORD_W-1:0];
      e.row = row[COORD_W-1:0];
      e.last_in_run = last;
      e.frame_done = done;
      pending_gradients = {pending_gradients, e};
    endfunction

    function void take_item(logic kind, logic [PIXEL_W-1:0] pix);
      int w;
      int c;
      int r;
      bit row_end;
      col3_t cur;
      col3_t left;
      w = row_length();
      c = (column_count > MAX_W - 1) ? MAX_W - 1 : column_count;
      r = row_count;
      row_end = (c >= w - 1);
      cur.m = line_current[c];
      if (kind == KIND_PIXEL) begin
        cur.b = pix;
        cur.t = (r == 1) ? pix : line_above[c];
      end else if (r >= 2) begin
        cur.t = line_above[c];
        cur.b = line_above[c];
      end else begin
        cur.t = cur.m;
        cur.b = cur.m;
      end
      if (r >= 1) begin
        if (c >= 1) begin
          left = (c == 1) ? cur : window[1];
          expect_gradient(sobel_magnitude(left, window[0], cur), c - 1, r - 1, !row_end, 1'b0);
        end
        if (row_end) begin
          expect_gradient(sobel_magnitude(window[0], cur, window[0]), c, r - 1, 1'b1,
                          kind == KIND_PAD);
        end
      end
      window[1] = window[0];
      window[0] = cur;
      if (kind == KIND_PIXEL) begin
        line_above[c] = line_current[c];
        line_current[c] = pix;
      end
      if (row_end) begin
        column_count = 0;
        if (kind == KIND_PAD) begin
          row_count = 0;
        end else if (row_count < MAX_H) begin
          row_count++;
        end
      end else begin
        column_count = c + 1;
      end
    endfunction

    task report(string what, res_t at, logic [31:0] got, logic [31:0] wanted);
      if (mismatches < 100) begin
        $display("mismatch %s at column %0d row %0d: got %0d, expected %0d",
                 what, at.column, at.row, got, wanted);
      end
      mismatches++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic last, logic done);
      res_t want;
      if (pending_gradients.size() == 0) begin
        want = '0;
        report("result with none pending", want, data[GRAD_W-1:0], 0);
        return;
      end
      want = pending_gradients.pop_front();
      if (data[GRAD_W-1:0] !== want.gradient)
        report("gradient", want, data[GRAD_W-1:0], want.gradient);
      if (data[GRAD_W +: COORD_W] !== want.column)
        report("column", want, data[GRAD_W +: COORD_W], want.column);
      if (data[GRAD_W+COORD_W +: COORD_W] !== want.row)
        report("row", want, data[GRAD_W+COORD_W +: COORD_W], want.row);
      if (last !== want.last_in_run)
        report("last_in_run", want, last, want.last_in_run);
      if (done !== want.frame_done)
        report("frame_done", want, done, want.frame_done);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIXEL_W-1:0] s_tdata = '0;     // pixel
  logic s_tuser = KIND_PIXEL;           // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // gradient, column, row, zero fill
  logic m_tlast;
  logic m_tuser;                        // frame_done

  gradient_scoreboard board = new();

  int burst_left = 0;
  int items_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_left = 0;
  int rx_tick = 0;
  rx_mode_e rx_mode = RX_FREE;
  int quiet_cycles = 0;

  sobel_gradient_threshold dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    rx_tick++;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_OFF;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_tick % 5 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [PIXEL_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 64);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= pix;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    board.take_item(kind, pix);
    items_sent++;
  endtask

  // waits for all pending gradients
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_gradients.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input int width, input int thresh);
    logic [CFG_DATA_W-1:0] junk;
    drain(SETTLE);
    junk = $urandom();
    apb_write(REG_IMAGE_WIDTH, {junk[CFG_DATA_W-1:WIDTH_REG_W], width[WIDTH_REG_W-1:0]});
    junk = $urandom();
    apb_write(REG_THRESHOLD, {junk[CFG_DATA_W-1:GRAD_W], thresh[GRAD_W-1:0]});
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2);
      1: return 3;
      default: return $urandom_range(4, FILL_WIDTH);
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] next_pixel(pix_style_e style,
                                                    logic [PIXEL_W-1:0] base);
    case (style)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      PIX_FLAT: return base;
      PIX_NEAR: return base + 8'($urandom_range(0, 15)) - 8'd8;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_rows(input int rows, input pix_style_e style);
    logic [PIXEL_W-1:0] base;
    base = 8'($urandom);
    repeat (rows * board.row_length()) send_item(KIND_PIXEL, next_pixel(style, base));
  endtask

  // pads until the frame ends, with stray pixels when noisy
  task automatic close_frame(input bit noisy);
    while (!board.frame_start()) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_item(KIND_PIXEL, 8'($urandom));
      end else begin
        send_item(KIND_PAD, 8'($urandom));
      end
    end
  endtask

  task automatic random_frame();
    int rows;
    bit noisy;
    pix_style_e style;
    logic [PIXEL_W-1:0] base;
    rows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) rows = $urandom_range(7, 14);
    style = pix_style_e'($urandom_range(0, 3));
    noisy = ($urandom_range(0, 3) == 0);
    base = 8'($urandom);
    repeat (rows * board.row_length()) begin
      if (noisy && $urandom_range(0, 29) == 0) begin
        send_item(KIND_PAD, 8'($urandom));
      end else begin
        send_item(KIND_PIXEL, next_pixel(style, base));
      end
      if (noisy && $urandom_range(0, 199) == 0) configure(pick_width(), board.threshold);
    end
    close_frame(noisy);
  endtask

  initial begin
    int random_start;
    int thresh;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // width below range acts as 3
    configure(0, 0);
    send_item(KIND_PIXEL, 8'hff);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PIXEL, 8'hff);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PIXEL, 8'hff);
    send_item(KIND_PIXEL, 8'h00);
    close_frame(1'b0);

    // one-row frame, then pads with no rows, at top threshold
    configure(1, 2047);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PIXEL, 8'hff);
    send_item(KIND_PIXEL, 8'h80);
    close_frame(1'b0);
    send_item(KIND_PAD, 8'hff);
    send_item(KIND_PAD, 8'h00);
    send_item(KIND_PAD, 8'h5a);

    // pad mid-row followed by a pixel
    configure(2, 0);
    send_item(KIND_PIXEL, 8'd17);
    send_item(KIND_PIXEL, 8'd200);
    send_item(KIND_PIXEL, 8'd90);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PAD, 8'h00);
    send_item(KIND_PIXEL, 8'hff);
    close_frame(1'b0);

    // widest random rows, fills every line entry they can reach
    configure(FILL_WIDTH, $urandom_range(0, 600));
    send_rows(2, PIX_RANDOM);
    close_frame(1'b0);

    // long receiver hold-off, then a pause mid-frame
    configure(16, 0);
    hold_requests++;
    send_rows(6, PIX_NEAR);
    drain(0);
    send_rows(2, PIX_EXTREME);
    close_frame(1'b0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: thresh = 0;
          1: thresh = 2047;
          2, 3: thresh = $urandom_range(0, 400);
          default: thresh = $urandom_range(0, 2047);
        endcase
        configure(pick_width(), thresh);
      end
      random_frame();
    end

    drain(SETTLE * 2);
    if (board.mismatches == 0 && board.pending_gradients.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
